>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the setpoint shaper.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MSS_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication
`define MSS_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

>>> rtl/core/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// Types, constants and saturation helpers of the setpoint shaper.
// ----------------------------------------------------------------------------
package mss_pkg;

    localparam logic [31:0] ONE_MS_Q24   = 32'd16777;
    localparam logic [31:0] MIN_STEP_Q24 = 32'd168;
    localparam logic [32:0] ONE_Q24      = 33'h0_0100_0000;
    localparam logic [31:0] Q_MAX        = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN        = 32'h8000_0000;

    localparam logic [31:0] FWD_TAU_RST  = 32'd3355443;
    localparam logic [31:0] TURN_TAU_RST = 32'd838861;
    localparam logic [30:0] FWD_LIM_RST  = 31'd1928724480;
    localparam logic [30:0] TURN_LIM_RST = 31'd1285816320;

    localparam logic [1:0] CFG_FWD_TAU  = 2'd0;
    localparam logic [1:0] CFG_TURN_TAU = 2'd1;
    localparam logic [1:0] CFG_FWD_LIM  = 2'd2;
    localparam logic [1:0] CFG_TURN_LIM = 2'd3;

    localparam int unsigned NUM_W  = 57;
    localparam int unsigned DEN_W  = 33;
    localparam int unsigned QUO_W  = 32;
    localparam int unsigned PROD_W = 65;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL_DV,
        OP_INTEG,
        OP_DIV_VA,
        OP_CIRC,
        OP_MUL_DT,
        OP_SET_DT,
        OP_DIV_AF,
        OP_TAKE_AF,
        OP_DIV_AT,
        OP_TAKE_AT,
        OP_DIV_REQ,
        OP_TAKE_REQ,
        OP_CLIP,
        OP_MUL_S,
        OP_ACC_MUL,
        OP_ACC2,
        OP_SMOOTH,
        OP_MUL_OUT,
        OP_FINISH,
        OP_PUSH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic axis;
    } t_cmd;

    typedef struct packed {
        logic action;
        logic radius_zero;
        logic div_busy;
        logic out_free;
    } t_stat;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic logic signed [33:0] ext34(input logic [31:0] v);
        return $signed({{2{v[31]}}, v});
    endfunction

    function automatic logic [32:0] mag34(input logic signed [33:0] v);
        logic [33:0] n;
        n = 34'd0 - v;
        return v[33] ? n[32:0] : v[32:0];
    endfunction

    function automatic logic [65:0] ext66(input logic [31:0] v);
        return {{34{v[31]}}, v};
    endfunction

    function automatic logic [31:0] sat_mag(input logic neg, input logic [64:0] m);
        logic [31:0] r;
        if (neg) begin
            r = (m >= 65'h0_8000_0000) ? Q_MIN : (32'd0 - m[31:0]);
        end else begin
            r = (m > 65'h0_7FFF_FFFF) ? Q_MAX : m[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_s(input logic [65:0] v);
        logic [31:0] r;
        if (v[65:31] == {35{v[65]}}) begin
            r = v[31:0];
        end else begin
            r = v[65] ? Q_MIN : Q_MAX;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/motion_setpoint_shaper_unit.sv
// ----------------------------------------------------------------------------
// motion_setpoint_shaper_unit
// Items are taken one at a time: the next is accepted in the cycle after the
// result is pushed. Up to five 32-step divisions run through the single
// shared divider, and a stalled result register holds the push.
// Reset (synchronous, active low) restores the sequencer and divider state
// and the configuration, history and output-valid registers to defaults.
// ----------------------------------------------------------------------------
module motion_setpoint_shaper_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // now_ms, meas_distance, meas_velocity, meas_angle, meas_turn_rate,
    // target_distance, target_angle, circle_radius, circle_speed,
    // drive_saturation, zero pad
    input  logic [295:0] i_s_axis_tdata,
    // action
    input  logic         i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // desired_distance, desired_angle
    output logic [63:0]  o_m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import mss_pkg::*;
    `include "assert_macros.svh"

    t_cmd  w_cmd;
    t_stat w_stat;

    mss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_stat     (w_stat),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    mss_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_action    (i_s_axis_tuser),
        .i_data      (i_s_axis_tdata[289:0]),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_dist  (o_m_axis_tdata[31:0]),
        .o_out_ang   (o_m_axis_tdata[63:32])
    );

    logic w_div_cmd;
    assign w_div_cmd = (w_cmd.op == OP_DIV_VA) || (w_cmd.op == OP_DIV_AF)
                    || (w_cmd.op == OP_DIV_AT) || (w_cmd.op == OP_DIV_REQ);

    `MSS_ASSERT_IMP(a_div_start_idle, i_clk, i_rst_n, w_div_cmd, !w_stat.div_busy)
    `MSS_ASSERT_IMP(a_push_when_free, i_clk, i_rst_n, w_cmd.op == OP_PUSH, w_stat.out_free)
    `MSS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
endmodule

>>> rtl/core/mss_div.sv
// ----------------------------------------------------------------------------
// mss_div
// Restoring divider, one quotient bit per cycle, with overflow flag.
// ----------------------------------------------------------------------------
module mss_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mss_pkg::NUM_W-1:0]   i_num,
    input  logic [mss_pkg::DEN_W-1:0]   i_den,
    output logic                        o_busy,
    output logic [mss_pkg::QUO_W-1:0]   o_quo,
    output logic                        o_ovf
);
    import mss_pkg::*;

    localparam int unsigned CNT_W = $clog2(QUO_W);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [QUO_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_ovf;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             take;

    always_comb begin
        trial = {r_rem, r_quo[QUO_W-1]};
        diff  = trial - {1'b0, r_den};
        take  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_ovf  <= (DEN_W'(i_num[NUM_W-1:QUO_W]) >= i_den);
            r_rem  <= DEN_W'(i_num[NUM_W-1:QUO_W]);
            r_quo  <= i_num[QUO_W-1:0];
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quo  <= {r_quo[QUO_W-2:0], take};
            r_cnt  <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(QUO_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_ovf  = r_ovf;
endmodule

>>> rtl/core/mss_ctrl.sv
// ----------------------------------------------------------------------------
// mss_ctrl
// Sequencer: steps the datapath through one item.
// ----------------------------------------------------------------------------
module mss_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  mss_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output mss_pkg::t_cmd  o_cmd
);
    import mss_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_MUL_DV, S_INTEG, S_DIV_VA, S_W_VA, S_CIRC,
        S_MUL_DT, S_SET_DT, S_DIV_AF, S_W_AF, S_TAKE_AF,
        S_DIV_AT, S_W_AT, S_TAKE_AT, S_DIV_REQ, S_W_REQ, S_TAKE_REQ,
        S_CLIP, S_MUL_S, S_ACC_MUL, S_ACC2, S_SMOOTH, S_MUL_OUT,
        S_FINISH, S_PUSH
    } t_state;

    t_state r_state;
    logic   r_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_axis <= 1'b0;
                    if (i_in_valid) begin
                        r_state <= S_MUL_DV;
                    end
                end
                S_MUL_DV: begin
                    r_state <= i_stat.action ? S_INTEG : S_MUL_DT;
                end
                S_INTEG:    r_state <= i_stat.radius_zero ? S_CIRC : S_DIV_VA;
                S_DIV_VA:   r_state <= S_W_VA;
                S_W_VA:     if (!i_stat.div_busy) r_state <= S_CIRC;
                S_CIRC:     r_state <= S_MUL_DT;
                S_MUL_DT:   r_state <= S_SET_DT;
                S_SET_DT:   r_state <= S_DIV_AF;
                S_DIV_AF:   r_state <= S_W_AF;
                S_W_AF:     if (!i_stat.div_busy) r_state <= S_TAKE_AF;
                S_TAKE_AF:  r_state <= S_DIV_AT;
                S_DIV_AT:   r_state <= S_W_AT;
                S_W_AT:     if (!i_stat.div_busy) r_state <= S_TAKE_AT;
                S_TAKE_AT:  r_state <= S_DIV_REQ;
                S_DIV_REQ:  r_state <= S_W_REQ;
                S_W_REQ:    if (!i_stat.div_busy) r_state <= S_TAKE_REQ;
                S_TAKE_REQ: r_state <= S_CLIP;
                S_CLIP:     r_state <= S_MUL_S;
                S_MUL_S:    r_state <= S_ACC_MUL;
                S_ACC_MUL:  r_state <= S_ACC2;
                S_ACC2:     r_state <= S_SMOOTH;
                S_SMOOTH:   r_state <= S_MUL_OUT;
                S_MUL_OUT:  r_state <= S_FINISH;
                S_FINISH: begin
                    if (r_axis) begin
                        r_state <= S_PUSH;
                    end else begin
                        r_axis  <= 1'b1;
                        r_state <= S_DIV_REQ;
                    end
                end
                S_PUSH:     if (i_stat.out_free) r_state <= S_IDLE;
                default:    r_state <= S_IDLE;
            endcase
        end
    end

    // the circle step multiply is harmless on position requests
    always_comb begin
        o_cmd.axis = r_axis;
        unique case (r_state)
            S_IDLE:     o_cmd.op = i_in_valid ? OP_LOAD : OP_NOP;
            S_MUL_DV:   o_cmd.op = OP_MUL_DV;
            S_INTEG:    o_cmd.op = OP_INTEG;
            S_DIV_VA:   o_cmd.op = OP_DIV_VA;
            S_CIRC:     o_cmd.op = OP_CIRC;
            S_MUL_DT:   o_cmd.op = OP_MUL_DT;
            S_SET_DT:   o_cmd.op = OP_SET_DT;
            S_DIV_AF:   o_cmd.op = OP_DIV_AF;
            S_TAKE_AF:  o_cmd.op = OP_TAKE_AF;
            S_DIV_AT:   o_cmd.op = OP_DIV_AT;
            S_TAKE_AT:  o_cmd.op = OP_TAKE_AT;
            S_DIV_REQ:  o_cmd.op = OP_DIV_REQ;
            S_TAKE_REQ: o_cmd.op = OP_TAKE_REQ;
            S_CLIP:     o_cmd.op = OP_CLIP;
            S_MUL_S:    o_cmd.op = OP_MUL_S;
            S_ACC_MUL:  o_cmd.op = OP_ACC_MUL;
            S_ACC2:     o_cmd.op = OP_ACC2;
            S_SMOOTH:   o_cmd.op = OP_SMOOTH;
            S_MUL_OUT:  o_cmd.op = OP_MUL_OUT;
            S_FINISH:   o_cmd.op = OP_FINISH;
            S_PUSH:     o_cmd.op = i_stat.out_free ? OP_PUSH : OP_NOP;
            default:    o_cmd.op = OP_NOP;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
endmodule

>>> rtl/core/mss_dpath.sv
// ----------------------------------------------------------------------------
// mss_dpath
// Registers, shared multiplier, divider and saturating arithmetic.
// ----------------------------------------------------------------------------
module mss_dpath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mss_pkg::t_cmd         i_cmd,
    output mss_pkg::t_stat        o_stat,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic                  i_action,
    input  logic [289:0]          i_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [31:0]           o_out_dist,
    output logic [31:0]           o_out_ang
);
    import mss_pkg::*;

    logic [31:0] r_tau_f, r_tau_t;
    logic [30:0] r_lim_f, r_lim_t;
    logic [31:0] r_last_ts, r_last_step;
    logic [31:0] r_sm_v, r_sm_w, r_si;

    logic        r_action;
    logic [31:0] r_now, r_x, r_v, r_a, r_w, r_tx, r_ta, r_r, r_spd;
    logic [1:0]  r_sat;
    logic [31:0] r_dt, r_alpha_f, r_alpha_t, r_req, r_nv, r_res_x, r_res_a;
    logic signed [59:0] r_acc;
    logic [PROD_W-1:0]  r_prod;
    logic        r_out_valid;
    logic [31:0] r_out_dist, r_out_ang;

    logic [31:0] tgt, pos, rate, smooth, alpha;
    logic [30:0] lim;
    logic signed [33:0] dsv, dtp, diff, dclip, lim34;
    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic        mul_en;
    logic [31:0] dv, va, sm;
    logic        dv_ok;
    logic [59:0] accm;
    logic [65:0] delta;
    logic [31:0] mr;
    logic [31:0] elapsed;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic        div_start, div_busy, div_ovf;
    logic [QUO_W-1:0] div_q;
    logic [64:0] qm;
    logic signed [59:0] pterm;

    always_comb begin
        tgt    = i_cmd.axis ? r_ta      : r_tx;
        pos    = i_cmd.axis ? r_a       : r_x;
        rate   = i_cmd.axis ? r_w       : r_v;
        smooth = i_cmd.axis ? r_sm_w    : r_sm_v;
        alpha  = i_cmd.axis ? r_alpha_t : r_alpha_f;
        lim    = i_cmd.axis ? r_lim_t   : r_lim_f;

        elapsed = r_now - r_last_ts;

        dsv = ext34(r_spd) - ext34(r_v);
        dtp = ext34(tgt) - ext34(pos);
        qm  = {32'd0, div_ovf, div_q};

        dv    = sat_mag(dsv[33], 65'(r_prod[64:24]));
        dv_ok = (!dv[31] && (r_sat[1] || r_sat == 2'b00))
             || ((dv[31] || dv == 32'd0) && !r_sat[1]);

        if (r_r == 32'd0) begin
            va = r_si[31] ? Q_MIN : ((r_si == 32'd0) ? 32'd0 : Q_MAX);
        end else begin
            va = sat_mag(r_si[31] != r_r[31], qm);
        end

        diff  = ext34(r_req) - ext34(rate);
        lim34 = $signed({3'b000, lim});
        if (diff > lim34) begin
            dclip = lim34;
        end else if (diff < -lim34) begin
            dclip = -lim34;
        end else begin
            dclip = diff;
        end

        pterm = $signed({1'b0, r_prod[58:0]});
        accm  = r_acc[59] ? (60'd0 - r_acc) : r_acc;
        sm    = sat_mag(r_acc[59], 65'(accm[59:24]));

        mr    = (mag32(smooth) < mag32(r_req)) ? mag32(smooth) : mag32(r_req);
        delta = r_req[31] ? (66'd0 - 66'(r_prod[64:24])) : 66'(r_prod[64:24]);

        mul_en = 1'b1;
        unique case (i_cmd.op)
            OP_MUL_DV:  begin mul_a = mag34(dsv);              mul_b = r_last_step; end
            OP_MUL_DT:  begin mul_a = {1'b0, elapsed};         mul_b = ONE_MS_Q24;  end
            OP_MUL_S:   begin
                mul_a = 33'(mag32(smooth));
                mul_b = 32'(ONE_Q24 - 33'(alpha));
            end
            OP_ACC_MUL: begin mul_a = 33'(mag32(r_nv));        mul_b = alpha;       end
            OP_MUL_OUT: begin mul_a = 33'(mr);                 mul_b = r_dt;        end
            default:    begin mul_a = '0; mul_b = '0; mul_en = 1'b0;             end
        endcase

        div_start = 1'b1;
        unique case (i_cmd.op)
            OP_DIV_VA:  begin
                div_num = NUM_W'({mag32(r_si), 16'd0});
                div_den = DEN_W'(mag32(r_r));
            end
            OP_DIV_AF:  begin
                div_num = NUM_W'({r_dt, 24'd0});
                div_den = DEN_W'(r_tau_f) + DEN_W'(r_dt);
            end
            OP_DIV_AT:  begin
                div_num = NUM_W'({r_dt, 24'd0});
                div_den = DEN_W'(r_tau_t) + DEN_W'(r_dt);
            end
            OP_DIV_REQ: begin
                div_num = {mag34(dtp), 24'd0};
                div_den = DEN_W'(r_dt);
            end
            default:    begin div_num = '0; div_den = '0; div_start = 1'b0; end
        endcase
    end

    mss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_q),
        .o_ovf   (div_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tau_f     <= FWD_TAU_RST;
            r_tau_t     <= TURN_TAU_RST;
            r_lim_f     <= FWD_LIM_RST;
            r_lim_t     <= TURN_LIM_RST;
            r_last_ts   <= '0;
            r_last_step <= ONE_MS_Q24;
            r_sm_v      <= '0;
            r_sm_w      <= '0;
            r_si        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FWD_TAU:  r_tau_f <= i_cfg_data;
                    CFG_TURN_TAU: r_tau_t <= i_cfg_data;
                    CFG_FWD_LIM:  r_lim_f <= i_cfg_data[30:0];
                    CFG_TURN_LIM: r_lim_t <= i_cfg_data[30:0];
                    default:      ;
                endcase
            end
            if (i_cmd.op == OP_PUSH) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_INTEG: begin
                    if (dv_ok) begin
                        r_si <= sat_s(ext66(r_si) + ext66(dv));
                    end
                end
                OP_MUL_DT: r_last_ts <= r_now;
                OP_SET_DT: begin
                    if (r_prod[64:32] != '0) begin
                        r_last_step <= 32'hFFFF_FFFF;
                    end else if (r_prod[31:0] < MIN_STEP_Q24) begin
                        r_last_step <= MIN_STEP_Q24;
                    end else begin
                        r_last_step <= r_prod[31:0];
                    end
                end
                OP_SMOOTH: begin
                    if (i_cmd.axis) begin
                        r_sm_w <= sm;
                    end else begin
                        r_sm_v <= sm;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_action <= i_action;
                r_now    <= i_data[31:0];
                r_x      <= i_data[63:32];
                r_v      <= i_data[95:64];
                r_a      <= i_data[127:96];
                r_w      <= i_data[159:128];
                r_tx     <= i_data[191:160];
                r_ta     <= i_data[223:192];
                r_r      <= i_data[255:224];
                r_spd    <= i_data[287:256];
                r_sat    <= i_data[289:288];
            end
            OP_CIRC: begin
                r_tx <= sat_s(ext66(r_x) + ext66(r_si));
                r_ta <= sat_s(ext66(r_a) + ext66(va));
            end
            OP_SET_DT: begin
                if (r_prod[64:32] != '0) begin
                    r_dt <= 32'hFFFF_FFFF;
                end else if (r_prod[31:0] < MIN_STEP_Q24) begin
                    r_dt <= MIN_STEP_Q24;
                end else begin
                    r_dt <= r_prod[31:0];
                end
            end
            OP_TAKE_AF:  r_alpha_f <= div_q;
            OP_TAKE_AT:  r_alpha_t <= div_q;
            OP_TAKE_REQ: r_req <= sat_mag(dtp[33], qm);
            OP_CLIP:     r_nv <= sat_s(ext66(rate) + {{32{dclip[33]}}, dclip});
            OP_ACC_MUL:  r_acc <= smooth[31] ? -pterm : pterm;
            OP_ACC2:     r_acc <= r_acc + (r_nv[31] ? -pterm : pterm);
            OP_FINISH: begin
                if (i_cmd.axis) begin
                    r_res_a <= sat_s(ext66(pos) + delta);
                end else begin
                    r_res_x <= sat_s(ext66(pos) + delta);
                end
            end
            OP_PUSH: begin
                r_out_dist <= r_res_x;
                r_out_ang  <= r_res_a;
            end
            default: ;
        endcase
    end

    assign o_stat.action      = r_action;
    assign o_stat.radius_zero = (r_r == 32'd0);
    assign o_stat.div_busy    = div_busy;
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_dist  = r_out_dist;
    assign o_out_ang   = r_out_ang;
endmodule
